### rtl/triangle_attribute_interpolator_top_defines.svh
// Assertion macros used by the interpolator top module.
`ifndef TRIANGLE_ATTRIBUTE_INTERPOLATOR_TOP_DEFINES_SVH
`define TRIANGLE_ATTRIBUTE_INTERPOLATOR_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TAI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tai assertion failed");

// Check a property on every clock edge, reset included.
`define TAI_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("tai assertion failed");

`endif

### rtl/tai_pkg.sv
package tai_pkg;

    localparam int ATTR_COUNT = 6;
    localparam int VTX_COUNT  = 3;
    localparam int SEL_W      = 2;

    // Datapath widths
    localparam int E_W     = 33;            // edge and point deltas
    localparam int P_W     = 2 * E_W;       // edge products
    localparam int D_W     = P_W + 1;       // determinant, np, nq
    localparam int LO_W    = 34;            // low split of np / nq
    localparam int HI_W    = D_W - LO_W;    // high split of np / nq
    localparam int PL_W    = LO_W + 1 + E_W;
    localparam int PH_W    = HI_W + E_W;
    localparam int HS_W    = PH_W + 1;
    localparam int LS_W    = PL_W + 1;
    localparam int N_W     = HS_W + LO_W;   // numerator sum
    localparam int MAG_W   = N_W - 1;
    localparam int NUM_W   = MAG_W + 2;     // 2|n| + det
    localparam int DEN_W   = D_W + 1;       // 2 det
    localparam int QB      = 40;            // quotient bits before saturation
    localparam int CMP_W   = DEN_W + QB;
    localparam int SUM_W   = QB + 2;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [SEL_W-1:0]   vertex_sel;
        logic signed [31:0] elem_0;
        logic signed [31:0] elem_1;
        logic signed [31:0] elem_2;
        logic signed [31:0] elem_3;
        logic signed [31:0] elem_4;
        logic signed [31:0] elem_5;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic               written;
        logic signed [31:0] attr_0;
        logic signed [31:0] attr_1;
        logic signed [31:0] attr_2;
        logic signed [31:0] attr_3;
        logic signed [31:0] attr_4;
        logic signed [31:0] attr_5;
    } t_out_item;

    typedef logic [ATTR_COUNT-1:0][31:0] t_attr_vec;

    typedef struct packed {
        logic valid;
        logic written;
    } t_ctl;

    typedef struct packed {
        t_ctl                              ctl;
        logic [D_W-1:0]                    det;
        logic [D_W-1:0]                    np;
        logic [D_W-1:0]                    nq;
        t_attr_vec                         av;
        logic [ATTR_COUNT-1:0][E_W-1:0]    bd;
        logic [ATTR_COUNT-1:0][E_W-1:0]    cd;
    } t_front;

    function automatic t_attr_vec elems_of(t_in_item it);
        t_attr_vec v;
        v[0] = it.elem_0;
        v[1] = it.elem_1;
        v[2] = it.elem_2;
        v[3] = it.elem_3;
        v[4] = it.elem_4;
        v[5] = it.elem_5;
        return v;
    endfunction

    function automatic t_out_item pack_out(logic written, t_attr_vec v);
        t_out_item o;
        o.written = written;
        o.attr_0  = v[0];
        o.attr_1  = v[1];
        o.attr_2  = v[2];
        o.attr_3  = v[3];
        o.attr_4  = v[4];
        o.attr_5  = v[5];
        return o;
    endfunction

    // Difference of two 32-bit signed words, exact in 33 bits
    function automatic logic [E_W-1:0] diff33(logic [31:0] a, logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

endpackage

### rtl/tai_front.sv
module tai_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_accept,
    input  tai_pkg::t_in_item i_item,
    output tai_pkg::t_front   o_front
);
    import tai_pkg::*;

    logic [31:0] r_store [VTX_COUNT][ATTR_COUNT];
    t_attr_vec   w_elems;

    // Stage 1: edges and deltas
    logic                               r1_valid;
    logic signed [E_W-1:0]              r1_e00, r1_e01, r1_e10, r1_e11, r1_dx, r1_dy;
    t_attr_vec                          r1_av;
    logic [ATTR_COUNT-1:0][E_W-1:0]     r1_bd, r1_cd;

    // Stage 2: products
    logic                               r2_valid;
    logic signed [P_W-1:0]              r2_p00, r2_p01, r2_pnp0, r2_pnp1, r2_pnq0, r2_pnq1;
    t_attr_vec                          r2_av;
    logic [ATTR_COUNT-1:0][E_W-1:0]     r2_bd, r2_cd;

    // Stage 3: determinant and numerators
    logic                               r3_valid;
    logic                               r3_det_pos;
    logic [D_W-1:0]                     r3_det, r3_np, r3_nq;
    t_attr_vec                          r3_av;
    logic [ATTR_COUNT-1:0][E_W-1:0]     r3_bd, r3_cd;
    logic [D_W-1:0]                     n_det;

    assign w_elems = elems_of(i_item);

    // Write one vertex on a load item
    always_ff @(posedge i_clk) begin
        for (int v = 0; v < VTX_COUNT; v++) begin
            if (i_accept && i_item.cmd == CMD_LOAD && i_item.vertex_sel == SEL_W'(v)) begin
                for (int a = 0; a < ATTR_COUNT; a++) begin
                    r_store[v][a] <= w_elems[a];
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_accept && i_item.cmd == CMD_EVAL;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    assign n_det = {r2_p00[P_W-1], r2_p00} - {r2_p01[P_W-1], r2_p01};

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_e00 <= diff33(r_store[1][0], r_store[0][0]);
            r1_e01 <= diff33(r_store[2][0], r_store[0][0]);
            r1_e10 <= diff33(r_store[1][1], r_store[0][1]);
            r1_e11 <= diff33(r_store[2][1], r_store[0][1]);
            r1_dx  <= diff33(i_item.point_x, r_store[0][0]);
            r1_dy  <= diff33(i_item.point_y, r_store[0][1]);
            for (int a = 0; a < ATTR_COUNT; a++) begin
                r1_av[a] <= r_store[0][a];
                r1_bd[a] <= diff33(r_store[1][a], r_store[0][a]);
                r1_cd[a] <= diff33(r_store[2][a], r_store[0][a]);
            end

            r2_p00  <= r1_e00 * r1_e11;
            r2_p01  <= r1_e01 * r1_e10;
            r2_pnp0 <= r1_e11 * r1_dx;
            r2_pnp1 <= r1_e01 * r1_dy;
            r2_pnq0 <= r1_e00 * r1_dy;
            r2_pnq1 <= r1_e10 * r1_dx;
            r2_av   <= r1_av;
            r2_bd   <= r1_bd;
            r2_cd   <= r1_cd;

            r3_det     <= n_det;
            r3_det_pos <= !n_det[D_W-1] && (n_det != '0);
            r3_np      <= {r2_pnp0[P_W-1], r2_pnp0} - {r2_pnp1[P_W-1], r2_pnp1};
            r3_nq      <= {r2_pnq0[P_W-1], r2_pnq0} - {r2_pnq1[P_W-1], r2_pnq1};
            r3_av      <= r2_av;
            r3_bd      <= r2_bd;
            r3_cd      <= r2_cd;
        end
    end

    assign o_front.ctl.valid   = r3_valid;
    assign o_front.ctl.written = r3_det_pos;
    assign o_front.det         = r3_det;
    assign o_front.np          = r3_np;
    assign o_front.nq          = r3_nq;
    assign o_front.av          = r3_av;
    assign o_front.bd          = r3_bd;
    assign o_front.cd          = r3_cd;

endmodule

### rtl/tai_lane.sv
module tai_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  tai_pkg::t_ctl             i_ctl,
    input  logic [tai_pkg::D_W-1:0]   i_det,
    input  logic [tai_pkg::D_W-1:0]   i_np,
    input  logic [tai_pkg::D_W-1:0]   i_nq,
    input  logic [31:0]               i_av,
    input  logic [tai_pkg::E_W-1:0]   i_bd,
    input  logic [tai_pkg::E_W-1:0]   i_cd,
    output tai_pkg::t_ctl             o_ctl,
    output logic [31:0]               o_attr
);
    import tai_pkg::*;

    localparam int PRE = 6;             // stages before the divider
    localparam int LAST = PRE + QB;

    t_ctl               r_ctl [1:LAST+1];
    logic [D_W-1:0]     r_det [1:PRE-2];
    logic [31:0]        r_av  [1:LAST];

    // L1 partial products, L2 partial sums, L3 numerator
    logic signed [PL_W-1:0] r1_plb, r1_plc;
    logic signed [PH_W-1:0] r1_phb, r1_phc;
    logic [HS_W-1:0]        r2_hi;
    logic [LS_W-1:0]        r2_lo;
    logic [N_W-1:0]         r3_n;
    logic                   r_neg [4:LAST];
    logic [MAG_W-1:0]       r4_mag;
    logic [NUM_W-1:0]       r5_num;
    logic [DEN_W-1:0]       r_den [5:LAST-1];
    logic                   r_sat [6:LAST];
    logic [NUM_W-1:0]       r_rem [6:LAST-1];
    logic [QB-1:0]          r_q   [6:LAST];
    logic [31:0]            r_attr;

    logic [CMP_W-1:0]       w_num_c, w_lim;
    logic [SUM_W-1:0]       w_qs, w_sum;
    logic [31:0]            w_res;

    // Control chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= LAST + 1; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (i_adv) begin
            r_ctl[1] <= i_ctl;
            for (int s = 2; s <= LAST + 1; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    assign w_num_c = CMP_W'(r5_num);
    assign w_lim   = {r_den[5], {QB{1'b0}}};

    // Front of the lane: multiply, sum, take magnitude, form the rounded dividend
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_av[1] <= i_av;
            for (int s = 2; s <= LAST; s++) begin
                r_av[s] <= r_av[s-1];
            end
            r_det[1] <= i_det;
            for (int s = 2; s < PRE - 1; s++) begin
                r_det[s] <= r_det[s-1];
            end

            r1_plb <= $signed({1'b0, i_np[LO_W-1:0]}) * $signed(i_bd);
            r1_plc <= $signed({1'b0, i_nq[LO_W-1:0]}) * $signed(i_cd);
            r1_phb <= $signed(i_np[D_W-1:LO_W]) * $signed(i_bd);
            r1_phc <= $signed(i_nq[D_W-1:LO_W]) * $signed(i_cd);

            r2_hi <= {r1_phb[PH_W-1], r1_phb} + {r1_phc[PH_W-1], r1_phc};
            r2_lo <= {r1_plb[PL_W-1], r1_plb} + {r1_plc[PL_W-1], r1_plc};

            r3_n <= {r2_hi, {LO_W{1'b0}}} + {{(N_W-LS_W){r2_lo[LS_W-1]}}, r2_lo};

            r_neg[4] <= r3_n[N_W-1];
            r4_mag   <= r3_n[N_W-1] ? MAG_W'(~r3_n + 1'b1) : r3_n[MAG_W-1:0];

            r_neg[5] <= r_neg[4];
            r5_num   <= {r4_mag, 1'b0} + NUM_W'(r_det[4]);
            r_den[5] <= {r_det[4], 1'b0};

            // Quotient too large for 40 bits: saturate
            r_neg[6] <= r_neg[5];
            r_den[6] <= r_den[5];
            r_sat[6] <= w_num_c >= w_lim;
            r_rem[6] <= r5_num;
            r_q[6]   <= '0;
        end
    end

    // Restoring divider, one quotient bit per stage
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int S = PRE + j;
        localparam int K = QB - 1 - j;
        logic [CMP_W-1:0] w_sh;
        logic             w_ge;
        logic [QB-1:0]    w_q;

        assign w_sh = CMP_W'(r_den[S]) << K;
        assign w_ge = CMP_W'(r_rem[S]) >= w_sh;

        always_comb begin
            w_q    = r_q[S];
            w_q[K] = w_ge;
        end

        if (j < QB - 1) begin : g_adv
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_neg[S+1] <= r_neg[S];
                    r_den[S+1] <= r_den[S];
                    r_sat[S+1] <= r_sat[S];
                    r_rem[S+1] <= w_ge ? r_rem[S] - w_sh[NUM_W-1:0] : r_rem[S];
                    r_q[S+1]   <= w_q;
                end
            end
        end else begin : g_last
            // Drop divisor and remainder after the last quotient bit
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_neg[S+1] <= r_neg[S];
                    r_sat[S+1] <= r_sat[S];
                    r_q[S+1]   <= w_q;
                end
            end
        end
    end

    // Add the rounded quotient to vertex a and clamp to 32 bits
    assign w_qs  = r_neg[LAST] ? SUM_W'(-{2'b00, r_q[LAST]}) : {2'b00, r_q[LAST]};
    assign w_sum = {{(SUM_W-32){r_av[LAST][31]}}, r_av[LAST]} + w_qs;

    always_comb begin
        if (r_sat[LAST] || (w_sum[SUM_W-1:31] != '0 && w_sum[SUM_W-1:31] != '1)) begin
            if (r_sat[LAST] ? r_neg[LAST] : w_sum[SUM_W-1]) begin
                w_res = 32'h8000_0000;
            end else begin
                w_res = 32'h7fff_ffff;
            end
        end else begin
            w_res = w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_attr <= r_ctl[LAST].written ? w_res : '0;
        end
    end

    assign o_ctl  = r_ctl[LAST+1];
    assign o_attr = r_attr;

endmodule

### rtl/triangle_attribute_interpolator_top.sv
// Barycentric attribute interpolator.
// Input channel (i_in_valid / o_in_ready / i_in_data): a load item (cmd 0)
// writes the six attributes of vertex a, b or c; vertex select 3 is ignored.
// Attributes 0 and 1 are screen x and y. An evaluate item (cmd 1) gives a
// point and yields one result item; loads yield none.
// Output channel (o_out_valid / i_out_ready / o_out_data): written = 1 with
// the six interpolated, saturated attributes, or written = 0 and all zero
// when the triangle's determinant is not positive.
// Throughput: one item per cycle; a new item is accepted every cycle the
// output side moves.
// The depth is set by the restoring divider, one quotient bit per stage.
// Loads take effect at accept, so an evaluate sees every earlier load.
// A stall on the output holds the whole pipeline and drops o_in_ready.
// Reset clears all valid bits; the vertex store is undefined until loaded.
module triangle_attribute_interpolator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tai_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tai_pkg::t_out_item o_out_data
);
    import tai_pkg::*;

`include "triangle_attribute_interpolator_top_defines.svh"

    logic      w_adv;
    logic      w_accept;
    t_front    w_front;
    t_ctl      w_ctl [ATTR_COUNT];
    t_attr_vec w_attr;

    // Advance the pipeline whenever the output register is free
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_accept   = i_in_valid && w_adv;

    tai_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .o_front  (w_front)
    );

    for (genvar a = 0; a < ATTR_COUNT; a++) begin : g_lane
        tai_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctl   (w_front.ctl),
            .i_det   (w_front.det),
            .i_np    (w_front.np),
            .i_nq    (w_front.nq),
            .i_av    (w_front.av[a]),
            .i_bd    (w_front.bd[a]),
            .i_cd    (w_front.cd[a]),
            .o_ctl   (w_ctl[a]),
            .o_attr  (w_attr[a])
        );
    end

    assign o_out_valid = w_ctl[0].valid;
    assign o_out_data  = pack_out(w_ctl[0].written, w_attr);

    `TAI_ASSERT(a_skip_zero, o_out_valid && !o_out_data.written |-> w_attr == '0)
    `TAI_ASSERT(a_stall_holds, !o_in_ready |=> o_out_valid)
    `TAI_ASSERT(a_lanes_agree, w_ctl[0] === w_ctl[ATTR_COUNT-1])
    `TAI_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid)

endmodule

### sim/tai_checker.sv
`timescale 1ns / 1ps

module tai_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  tai_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tai_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count,
    output int                 o_skip_count
);
    import tai_pkg::*;

    // Vertex store mirror: [vertex][attribute]
    logic signed [31:0] vtx_mem [VTX_COUNT][ATTR_COUNT];
    t_out_item          expected_results [$];

    initial begin
        o_fail_count   = 0;
        o_result_count = 0;
        o_skip_count   = 0;
    end

    assign o_pending = expected_results.size();

    // Round n/d to nearest, ties away from zero, d > 0, then add base and saturate
    function automatic logic signed [31:0] interp_one(logic signed [31:0] base,
                                                      logic signed [255:0] n,
                                                      logic signed [255:0] d);
        logic signed [255:0] mag;
        logic signed [255:0] q;
        logic signed [255:0] sum;
        mag = (n < 0) ? -n : n;
        q   = (2 * mag + d) / (2 * d);
        if (n < 0) q = -q;
        sum = q + base;
        if (sum > 256'sd2147483647) return 32'h7fffffff;
        if (sum < -256'sd2147483648) return 32'h80000000;
        return sum[31:0];
    endfunction

    // Compute the result of an evaluate against the current store
    function automatic t_out_item interpolate(logic signed [31:0] px,
                                              logic signed [31:0] py);
        logic signed [255:0] e00, e01, e10, e11, dx, dy, det, np, nq, bd, cd;
        t_attr_vec           v;
        e00 = 256'(vtx_mem[1][0]) - 256'(vtx_mem[0][0]);
        e01 = 256'(vtx_mem[2][0]) - 256'(vtx_mem[0][0]);
        e10 = 256'(vtx_mem[1][1]) - 256'(vtx_mem[0][1]);
        e11 = 256'(vtx_mem[2][1]) - 256'(vtx_mem[0][1]);
        dx  = 256'(px) - 256'(vtx_mem[0][0]);
        dy  = 256'(py) - 256'(vtx_mem[0][1]);
        det = e00 * e11 - e01 * e10;
        if (det <= 0) return pack_out(1'b0, '0);
        np = e11 * dx - e01 * dy;
        nq = e00 * dy - e10 * dx;
        for (int i = 0; i < ATTR_COUNT; i++) begin
            bd = 256'(vtx_mem[1][i]) - 256'(vtx_mem[0][i]);
            cd = 256'(vtx_mem[2][i]) - 256'(vtx_mem[0][i]);
            v[i] = interp_one(vtx_mem[0][i], np * bd + nq * cd, det);
        end
        return pack_out(1'b1, v);
    endfunction

    // Apply accepted items to the mirror and queue expectations
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && i_in_ready) begin
            if (i_in_data.cmd == CMD_LOAD) begin
                if (i_in_data.vertex_sel < VTX_COUNT) begin
                    vtx_mem[i_in_data.vertex_sel][0] = i_in_data.elem_0;
                    vtx_mem[i_in_data.vertex_sel][1] = i_in_data.elem_1;
                    vtx_mem[i_in_data.vertex_sel][2] = i_in_data.elem_2;
                    vtx_mem[i_in_data.vertex_sel][3] = i_in_data.elem_3;
                    vtx_mem[i_in_data.vertex_sel][4] = i_in_data.elem_4;
                    vtx_mem[i_in_data.vertex_sel][5] = i_in_data.elem_5;
                end
            end else begin
                expected_results.push_back(interpolate(i_in_data.point_x,
                                                       i_in_data.point_y));
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, i_out_data);
                o_fail_count++;
            end else begin
                exp_item = expected_results.pop_front();
                o_result_count++;
                if (!exp_item.written) o_skip_count++;
                if (exp_item.written !== i_out_data.written)
                    $display("%0t: written exp %b got %b", $time,
                             exp_item.written, i_out_data.written);
                if (exp_item.attr_0 !== i_out_data.attr_0)
                    $display("%0t: attr_0 exp %h got %h", $time,
                             exp_item.attr_0, i_out_data.attr_0);
                if (exp_item.attr_1 !== i_out_data.attr_1)
                    $display("%0t: attr_1 exp %h got %h", $time,
                             exp_item.attr_1, i_out_data.attr_1);
                if (exp_item.attr_2 !== i_out_data.attr_2)
                    $display("%0t: attr_2 exp %h got %h", $time,
                             exp_item.attr_2, i_out_data.attr_2);
                if (exp_item.attr_3 !== i_out_data.attr_3)
                    $display("%0t: attr_3 exp %h got %h", $time,
                             exp_item.attr_3, i_out_data.attr_3);
                if (exp_item.attr_4 !== i_out_data.attr_4)
                    $display("%0t: attr_4 exp %h got %h", $time,
                             exp_item.attr_4, i_out_data.attr_4);
                if (exp_item.attr_5 !== i_out_data.attr_5)
                    $display("%0t: attr_5 exp %h got %h", $time,
                             exp_item.attr_5, i_out_data.attr_5);
                if (exp_item !== i_out_data) o_fail_count++;
            end
        end
    end

endmodule

### sim/tb_triangle_attribute_interpolator_top.sv
`timescale 1ns / 1ps

module tb_triangle_attribute_interpolator_top;
    import tai_pkg::*;

    localparam int  RAND_ITEMS  = 900;
    localparam int  LATENCY     = 50;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  IN_W        = $bits(t_in_item);

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    int  fail_count;
    int  pending;
    int  result_count;
    int  skip_count;
    int  cycle_count;
    int  load_count;
    bit  calm_phase;
    bit  long_hold;

    triangle_attribute_interpolator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    tai_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_data     (o_out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_skip_count   (skip_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 3) << 16;
            3: return $urandom_range(0, 1) ? 32'(-$signed($urandom_range(0, 300))) :
                   32'($urandom_range(0, 300));
            default: return $urandom();
        endcase
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (it.cmd == CMD_LOAD) load_count++;
    endtask

    task automatic idle_in();
        if (!calm_phase && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic load_vertex(int sel, logic [31:0] x, logic [31:0] y, bit rand_attr);
        t_in_item it;
        it = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom()});
        it.cmd = CMD_LOAD;
        it.vertex_sel = sel[1:0];
        it.elem_0 = x;
        it.elem_1 = y;
        if (!rand_attr) begin
            it.elem_2 = rand_word();
            it.elem_3 = rand_word();
        end
        send_item(it);
    endtask

    task automatic eval_point(logic [31:0] x, logic [31:0] y);
        t_in_item it;
        it = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom()});
        it.cmd = CMD_EVAL;
        it.point_x = x;
        it.point_y = y;
        send_item(it);
    endtask

    // Random triangle around a base point, mostly modest sizes
    task automatic load_triangle(bit wide_range);
        logic [31:0] bx, by;
        bx = wide_range ? $urandom() : ($urandom_range(0, 200) << 16);
        by = wide_range ? $urandom() : ($urandom_range(0, 200) << 16);
        load_vertex(0, bx, by, 1);
        idle_in();
        load_vertex(1, bx + ($urandom_range(0, 50) << 16) + $urandom_range(0, 65535),
                    by + $urandom() % (20 << 16), $urandom_range(0, 1));
        idle_in();
        load_vertex(2, bx + $urandom() % (20 << 16),
                    by + ($urandom_range(0, 50) << 16) + $urandom_range(0, 65535),
                    $urandom_range(0, 1));
    endtask

    // Receiver side: random stall bursts, one long hold on request
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_in_item it;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        calm_phase = 1'b0;
        long_hold  = 1'b0;
        load_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unit triangle, corners, outside point, extremes
        load_vertex(0, 32'h0, 32'h0, 0);
        load_vertex(1, 32'h0001_0000, 32'h0, 0);
        load_vertex(2, 32'h0, 32'h0001_0000, 0);
        eval_point(32'h0, 32'h0);
        eval_point(32'h0001_0000, 32'h0);
        eval_point(32'h0000_4000, 32'h0000_8000);
        eval_point(32'h7fffffff, 32'h80000000);
        eval_point(32'h80000000, 32'h7fffffff);
        // Vertex select 3 must not change the store
        it = '1;
        it.cmd = CMD_LOAD;
        send_item(it);
        eval_point(32'h0000_8000, 32'h0000_8000);
        // Tiny triangle: huge extrapolation saturates
        load_vertex(1, 32'h1, 32'h0, 0);
        load_vertex(2, 32'h0, 32'h1, 0);
        eval_point(32'h7fffffff, 32'h7fffffff);
        eval_point(32'h80000000, 32'h80000000);
        // Clockwise and degenerate triangles report not written
        load_vertex(2, 32'h0, 32'hffff_0000, 0);
        eval_point(32'h0, 32'h0);
        load_vertex(2, 32'h0002_0000, 32'h0, 0);
        eval_point(32'h0, 32'h0);
        // Extreme corners
        load_vertex(0, 32'h80000000, 32'h80000000, 0);
        load_vertex(1, 32'h7fffffff, 32'h80000000, 0);
        load_vertex(2, 32'h80000000, 32'h7fffffff, 0);
        eval_point(32'h0, 32'h0);
        eval_point(32'h7fffffff, 32'h7fffffff);

        // Fill the block while the receiver holds off
        long_hold = 1'b1;
        repeat (120) begin
            eval_point($urandom(), $urandom());
        end

        // Random: mostly triangles followed by queries, some noise
        while (load_count + result_count < RAND_ITEMS && cycle_count < CYCLE_LIMIT / 2) begin
            if ($urandom_range(0, 9) == 0) begin
                it = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom(), $urandom()});
                if (it.cmd == CMD_EVAL) it.point_x = rand_word();
                send_item(it);
            end else begin
                load_triangle($urandom_range(0, 7) == 0);
                repeat ($urandom_range(1, 12)) begin
                    idle_in();
                    eval_point(rand_word(), rand_word());
                end
            end
            idle_in();
            // While the load count lies in 101..109, pause the sender until the pipeline drains
            if (load_count > 100 && load_count < 110) begin
                i_in_valid <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
            if (load_count + result_count > RAND_ITEMS * 4 / 5) calm_phase = 1'b1;
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("Covered %0d loads and %0d results, %0d with non-positive determinant.",
                 load_count, result_count, skip_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
